### hdl/fir_pkg.sv
package fir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int OP_W       = 2;
  localparam int TAP_IDX_W  = 6;
  localparam int TAPCNT_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_FILTER  = 2'd0;
  localparam logic [OP_W-1:0] OP_COEF_WR = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFFS_VALID = 2'd1;

  localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = 7'd51;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
  } mac_sts_t;

endpackage

### hdl/fir_if.sv
interface fir_in_if import fir_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [TAP_IDX_W-1:0]       tap_index;
  logic signed [SAMPLE_W-1:0] tap_value;

  modport source (output valid, output operation, output sample_value,
                  output tap_index, output tap_value, input ready);
  modport sink   (input valid, input operation, input sample_value,
                  input tap_index, input tap_value, output ready);
endinterface

interface fir_out_if import fir_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered_value;
  logic                       clipped;

  modport source (output valid, output filtered_value, output clipped, input ready);
  modport sink   (input valid, input filtered_value, input clipped, output ready);
endinterface

interface fir_cfg_if import fir_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/fir_filter_mac.sv
// channel  dir  beat contents                                        handshake
// in_ch    in   operation, sample_value, tap_index, tap_value          valid/ready
// out_ch   out  filtered_value, clipped                                valid/ready
// cfg_ch   in   index (0 tap_count, 1 coeffs_valid), data              valid/ready
//
// a filter beat reads n = min(tap_count, MAX_TAPS) taps, one tap per cycle
// through the shared read ports and mac; with coefficients not valid it skips them and gives zero
// coefficient writes and ignored codes are taken in the idle state; a clear sweeps the whole history
// after reset a clearing pass zeroes both memories, in_ready low
// out_ch has its own output register: the next beat is taken while a result waits
// cfg_ch is always ready
module fir_filter_mac import fir_pkg::*; #(
  parameter int MAX_TAPS       = 64,
  parameter int COEF_FRAC_BITS = 15
) (
  input logic       clk,
  input logic       rst_n,
  fir_in_if.sink    in_ch,
  fir_out_if.source out_ch,
  fir_cfg_if.sink   cfg_ch
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW    = $clog2(MAX_TAPS + 1);
  localparam int ACC_W = 2 * SAMPLE_W + CW + 1;
  localparam logic [AW-1:0] LAST_POS = AW'(MAX_TAPS - 1);

  state_t state_r, state_nxt;

  // control registers
  logic [AW-1:0]       clr_idx_r;
  logic                clr_coef_r;
  logic [TAPCNT_W-1:0] tap_count_r;
  logic                coeffs_valid_r;
  logic [AW-1:0]       newest_r;
  logic [AW-1:0]       rd_pos_r;
  logic [CW-1:0]       k_r;
  logic                rd_vld_r;
  logic                zero_r;
  logic                out_valid_r;

  // payload registers
  logic signed [SAMPLE_W-1:0] hist_q_r;
  logic signed [SAMPLE_W-1:0] coef_q_r;
  logic signed [SAMPLE_W-1:0] out_value_r;
  logic                       out_clip_r;

  // the two memories
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];

  logic                       hist_we;
  logic [AW-1:0]              hist_waddr;
  logic signed [SAMPLE_W-1:0] hist_wdata;
  logic                       coef_we;
  logic [AW-1:0]              coef_waddr;
  logic signed [SAMPLE_W-1:0] coef_wdata;

  logic [CW-1:0]              n_w;
  logic [AW-1:0]              newest_inc;
  logic [AW-1:0]              rd_pos_dec;
  logic                       issue;
  logic                       mac_done;
  logic                       out_load;
  logic                       in_accept;

  mac_ctl_t                   mac_ctl;
  mac_sts_t                   mac_sts;
  logic signed [SAMPLE_W-1:0] mac_result;
  logic                       mac_clip;

  assign in_accept = in_ch.valid && in_ch.ready;

  // taps in use, clamped to the built size
  assign n_w = (int'(tap_count_r) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(tap_count_r);

  // circular pointer steps
  assign newest_inc = (newest_r == LAST_POS) ? '0 : newest_r + 1'b1;
  assign rd_pos_dec = (rd_pos_r == '0) ? LAST_POS : rd_pos_r - 1'b1;

  // one tap read per cycle, newest sample with coefficient 0 first
  assign issue    = (state_r == ST_MAC) && (k_r != n_w);
  // all taps issued, read stage and product stage drained
  assign mac_done = (k_r == n_w) && !rd_vld_r && !mac_sts.busy;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == LAST_POS) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.operation)
            OP_FILTER: state_nxt = coeffs_valid_r ? ST_MAC : ST_DONE;
            OP_CLEAR:  state_nxt = ST_CLEAR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MAC: begin
        if (mac_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine: ready, memory writes, mac control
  always_comb begin
    in_ch.ready   = 1'b0;
    hist_we       = 1'b0;
    hist_waddr    = clr_idx_r;
    hist_wdata    = '0;
    coef_we       = 1'b0;
    coef_waddr    = clr_idx_r;
    coef_wdata    = '0;
    mac_ctl.clear = 1'b0;
    mac_ctl.valid = rd_vld_r;
    case (state_r)
      ST_CLEAR: begin
        // sweep zeroes history; coefficients too on the pass after reset
        hist_we = 1'b1;
        coef_we = clr_coef_r;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          case (in_ch.operation)
            OP_FILTER: begin
              // push only while coefficients are marked valid
              if (coeffs_valid_r) begin
                hist_we       = 1'b1;
                hist_waddr    = newest_inc;
                hist_wdata    = in_ch.sample_value;
                mac_ctl.clear = 1'b1;
              end
            end
            OP_COEF_WR: begin
              // writes past the built size are dropped
              if (int'(in_ch.tap_index) < MAX_TAPS) begin
                coef_we    = 1'b1;
                coef_waddr = AW'(in_ch.tap_index);
                coef_wdata = in_ch.tap_value;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_idx_r      <= '0;
      clr_coef_r     <= 1'b1;
      tap_count_r    <= TAP_COUNT_RST;
      coeffs_valid_r <= 1'b0;
      newest_r       <= '0;
      rd_pos_r       <= '0;
      k_r            <= '0;
      rd_vld_r       <= 1'b0;
      zero_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;

      // register writes; unknown indexes fall through
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_TAP_COUNT:    tap_count_r    <= TAPCNT_W'(cfg_ch.data);
          CFG_COEFFS_VALID: coeffs_valid_r <= cfg_ch.data[0];
          default: ;
        endcase
      end

      if (state_r == ST_CLEAR) begin
        if (clr_idx_r == LAST_POS) begin
          clr_idx_r  <= '0;
          clr_coef_r <= 1'b0;
        end else begin
          clr_idx_r <= clr_idx_r + 1'b1;
        end
      end

      if (in_accept) begin
        case (in_ch.operation)
          OP_FILTER: begin
            zero_r <= !coeffs_valid_r;
            if (coeffs_valid_r) begin
              newest_r <= newest_inc;
              rd_pos_r <= newest_inc;
              k_r      <= '0;
            end
          end
          OP_CLEAR: begin
            newest_r  <= '0;
            clr_idx_r <= '0;
          end
          default: ;
        endcase
      end

      if (issue) begin
        rd_pos_r <= rd_pos_dec;
        k_r      <= k_r + 1'b1;
      end

      // output register frees as soon as the sink takes the beat
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= zero_r ? '0 : mac_result;
      out_clip_r  <= zero_r ? 1'b0 : mac_clip;
    end
  end

  // history memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_q_r <= hist_mem[rd_pos_r];
  end

  // coefficient memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_waddr] <= coef_wdata;
    coef_q_r <= coef_mem[k_r[AW-1:0]];
  end

  fir_mac #(
    .ACC_W     (ACC_W),
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .sample_i (hist_q_r),
    .coef_i   (coef_q_r),
    .sts      (mac_sts),
    .result_o (mac_result),
    .clip_o   (mac_clip)
  );

  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_value = out_value_r;
  assign out_ch.clipped        = out_clip_r;

endmodule

### hdl/fir_mac.sv
module fir_mac import fir_pkg::*; #(
  parameter int ACC_W     = 40,
  parameter int FRAC_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   ctl,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [SAMPLE_W-1:0] coef_i,
  output mac_sts_t                   sts,
  output logic signed [SAMPLE_W-1:0] result_o,
  output logic                       clip_o
);

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

  logic signed [2*SAMPLE_W-1:0] prod_r;
  logic                         prod_vld_r;
  logic signed [ACC_W-1:0]      acc_r;
  logic signed [ACC_W-1:0]      shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.valid && !ctl.clear;
    end
  end

  // product stage, then accumulate
  always_ff @(posedge clk) begin
    prod_r <= sample_i * coef_i;
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // floor shift and saturate
  assign shifted = acc_r >>> FRAC_BITS;

  always_comb begin
    clip_o = 1'b0;
    if (shifted > SAT_MAX) begin
      result_o = SAMPLE_W'(SAT_MAX);
      clip_o   = 1'b1;
    end else if (shifted < SAT_MIN) begin
      result_o = SAMPLE_W'(SAT_MIN);
      clip_o   = 1'b1;
    end else begin
      result_o = shifted[SAMPLE_W-1:0];
    end
  end

  assign sts.busy = prod_vld_r;

endmodule

### hdl/fir_chk.sv
module fir_chk import fir_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [OP_W-1:0]            in_operation,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] filtered_value,
  input logic                       clipped
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(filtered_value) && $stable(clipped))
    else $error("result payload changed while stalled");

  // clearing pass follows reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during post-reset clear");

  // a clear sweeps the delay line before the next beat
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_CLEAR) |=> !in_ready)
    else $error("input ready right after a clear");

  // a clipped result sits at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clipped |-> (filtered_value == 16'sh7fff) || (filtered_value == 16'sh8000))
    else $error("clipped result not at the 16-bit limit");

endmodule

bind fir_filter_mac fir_chk u_fir_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_operation   (in_ch.operation),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .filtered_value (out_ch.filtered_value),
  .clipped        (out_ch.clipped)
);

### tb/fir_mac_checker.sv
`timescale 1ns / 100ps

module fir_mac_checker import fir_pkg::*; #(
  parameter int MAX_TAPS       = 64,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  fir_in_if           in_mon,
  fir_out_if          out_mon,
  fir_cfg_if          cfg_mon,
  output int unsigned err_count,
  output int unsigned pending
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       clip;
  } fir_result_t;

  logic signed [SAMPLE_W-1:0] history_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
  int                         newest_slot;
  logic [TAPCNT_W-1:0]        tap_count;
  logic                       coeffs_valid;
  fir_result_t                filter_results_q [$];
  int unsigned                fail_total;

  // with coefficients valid, push one sample and form the saturated sum of products; else zero
  function automatic fir_result_t filter_sample(logic signed [SAMPLE_W-1:0] x);
    fir_result_t res;
    longint      acc;
    longint      y;
    int          n;
    int          pos;
    res = '0;
    acc = 0;
    if (!coeffs_valid) return res;
    newest_slot = (newest_slot + 1) % MAX_TAPS;
    history_mem[newest_slot] = x;
    n = (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
    for (int k = 0; k < n; k++) begin
      pos = (newest_slot + MAX_TAPS - k) % MAX_TAPS;
      acc += longint'(history_mem[pos]) * longint'(coef_mem[k]);
    end
    y = acc >>> COEF_FRAC_BITS;
    if (y > 32767) begin
      y = 32767;
      res.clip = 1'b1;
    end else if (y < -32768) begin
      y = -32768;
      res.clip = 1'b1;
    end
    res.value = y[SAMPLE_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    fir_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        history_mem[i] = '0;
        coef_mem[i]    = '0;
      end
      newest_slot  = 0;
      tap_count    = TAP_COUNT_RST;
      coeffs_valid = 1'b0;
      fail_total   = 0;
      filter_results_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_TAP_COUNT:    tap_count = cfg_mon.data[TAPCNT_W-1:0];
          CFG_COEFFS_VALID: coeffs_valid = cfg_mon.data[0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        if (filter_results_q.size() == 0) begin
          $error("result beat with nothing expected: filtered_value %0d clipped %0b",
                 out_mon.filtered_value, out_mon.clipped);
          fail_total++;
        end else begin
          want = filter_results_q.pop_front();
          if (out_mon.filtered_value !== want.value) begin
            $error("filtered_value mismatch: expected %0d, actual %0d",
                   want.value, out_mon.filtered_value);
            fail_total++;
          end
          if (out_mon.clipped !== want.clip) begin
            $error("clipped mismatch: expected %0b, actual %0b", want.clip, out_mon.clipped);
            fail_total++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.operation)
          OP_FILTER:  filter_results_q.push_back(filter_sample(in_mon.sample_value));
          OP_COEF_WR: begin
            if (in_mon.tap_index < MAX_TAPS) coef_mem[in_mon.tap_index] = in_mon.tap_value;
          end
          OP_CLEAR: begin
            for (int i = 0; i < MAX_TAPS; i++) history_mem[i] = '0;
            newest_slot = 0;
          end
          default: ;
        endcase
      end
    end
    // nonblocking so the stimulus side always reads the pre-edge count
    pending   <= filter_results_q.size();
    err_count <= fail_total;
  end

endmodule

### tb/tb_fir_filter_mac.sv
`timescale 1ns / 100ps

module tb_fir_filter_mac import fir_pkg::*; ();

  localparam int MAX_TAPS       = 64;
  localparam int COEF_FRAC_BITS = 15;
  localparam int HOLD_CYCLES    = 300;           // long receiver hold-off
  localparam int SETTLE_CYCLES  = MAX_TAPS + 16; // a clear may still run after last result
  localparam int DRAIN_LIMIT    = 20000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 110;

  // codes the block must ignore
  localparam logic [OP_W-1:0]      OP_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

  logic        clk;
  logic        rst_n;
  int unsigned chk_errors;
  int unsigned pending;
  int unsigned drain_failures;
  bit          quiet;     // no idling on either side
  bit          hold_req;  // ask the receiver for a long hold-off

  fir_in_if  in_bus ();
  fir_out_if out_bus ();
  fir_cfg_if cfg_bus ();

  fir_filter_mac #(
    .MAX_TAPS       (MAX_TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  fir_mac_checker #(
    .MAX_TAPS       (MAX_TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_bus),
    .out_mon   (out_bus),
    .cfg_mon   (cfg_bus),
    .err_count (chk_errors),
    .pending   (pending)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // overall limit: far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request, steady at the end
  initial begin
    forever begin
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // one input beat; holds valid until taken, then maybe an idle burst
  task automatic send_beat(input logic [OP_W-1:0] op,
                           input logic signed [SAMPLE_W-1:0] sample,
                           input logic [TAP_IDX_W-1:0] idx,
                           input logic signed [SAMPLE_W-1:0] coef);
    in_bus.valid        <= 1'b1;
    in_bus.operation    <= op;
    in_bus.sample_value <= sample;
    in_bus.tap_index    <= idx;
    in_bus.tap_value    <= coef;
    do @(posedge clk); while (!in_bus.ready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // stop offering beats until every pending result has come out
  task automatic wait_results();
    int guard;
    guard = 0;
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending != 0) begin
      $error("results still outstanding after drain: %0d", pending);
      drain_failures++;
    end
  endtask

  // block idle: no results due and no clear or filter pass still running
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // program both registers, optionally the spare indexes too; upper data bits of the valid flag are noise
  task automatic configure(input logic [TAPCNT_W-1:0] taps, input logic cv,
                           input bit spare);
    logic [CFG_DATA_W-1:0] cv_word;
    cv_word = CFG_DATA_W'($urandom);
    cv_word[0] = cv;
    write_reg(CFG_TAP_COUNT, taps);
    write_reg(CFG_COEFFS_VALID, cv_word);
    if (spare) begin
      write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom));
      write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
    end
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // mostly samples, some coefficient loads, a few clears and ignored codes
  task automatic send_random_beat();
    int               pick;
    logic [OP_W-1:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 78)      op = OP_FILTER;
    else if (pick < 90) op = OP_COEF_WR;
    else if (pick < 95) op = OP_CLEAR;
    else                op = OP_RESERVED;
    // every field carries random content, whatever the operation
    send_beat(op, pick_sample(), TAP_IDX_W'($urandom), pick_sample());
  endtask

  function automatic logic [TAPCNT_W-1:0] pick_taps();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return TAPCNT_W'(MAX_TAPS);
      2:       return TAPCNT_W'($urandom_range(MAX_TAPS + 1, 127));
      3, 4:    return TAPCNT_W'($urandom_range(9, MAX_TAPS - 1));
      default: return TAPCNT_W'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    drain_failures = 0;
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.operation    <= OP_FILTER;
    in_bus.sample_value <= '0;
    in_bus.tap_index    <= '0;
    in_bus.tap_value    <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= CFG_TAP_COUNT;
    cfg_bus.data        <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // let the power-up clearing pass finish
    repeat (SETTLE_CYCLES) @(posedge clk);

    // directed: coefficients not yet valid, samples give zero and are not stored
    send_beat(OP_FILTER, S_MAX, '0, '0);
    send_beat(OP_FILTER, S_MIN, '1, '1);
    // load extreme taps, lowest and highest index
    send_beat(OP_COEF_WR, '0, 6'd0, S_MAX);
    send_beat(OP_COEF_WR, '0, 6'd1, S_MAX);
    send_beat(OP_COEF_WR, '0, 6'd2, S_MIN);
    send_beat(OP_COEF_WR, '0, 6'd3, 16'sh4000);
    send_beat(OP_COEF_WR, '0, 6'd63, S_MIN);
    settle();
    configure(TAPCNT_W'(MAX_TAPS), 1'b1, 1'b1);
    // full-scale samples drive both saturation directions
    send_beat(OP_FILTER, S_MAX, '0, '0);
    send_beat(OP_FILTER, S_MAX, '0, '0);
    send_beat(OP_FILTER, S_MIN, '0, '0);
    send_beat(OP_FILTER, S_MIN, '0, '0);
    send_beat(OP_FILTER, '0, '0, '0);
    // ignored code, then clear, then a sample into the empty line
    send_beat(OP_RESERVED, S_MAX, '1, S_MAX);
    send_beat(OP_CLEAR, S_MIN, '1, S_MIN);
    send_beat(OP_FILTER, 16'sd1, '0, '0);
    // zero taps: output zero but the sample still enters the line
    settle();
    configure('0, 1'b1, 1'b0);
    send_beat(OP_FILTER, S_MIN, '0, '0);
    settle();
    configure(7'd1, 1'b1, 1'b0);
    send_beat(OP_FILTER, S_MAX, '0, '0);
    // tap count above the built size saturates; old samples reappear
    settle();
    configure(7'd127, 1'b1, 1'b0);
    send_beat(OP_FILTER, S_MIN, '0, '0);
    send_beat(OP_FILTER, 16'sd12345, '0, '0);
    settle();
    configure(TAPCNT_W'(MAX_TAPS), 1'b0, 1'b0);
    send_beat(OP_FILTER, 16'sd100, '0, '0);

    // random phases, each under its own setting
    for (int p = 0; p < PHASES; p++) begin
      logic [TAPCNT_W-1:0] taps;
      settle();
      taps = pick_taps();
      configure(taps, ($urandom_range(0, 7) != 0), ($urandom_range(0, 2) == 0));
      // last phase runs flat out on both sides
      if (p == PHASES - 1) quiet = 1'b1;
      // back up the block behind a stalled receiver
      if (p == 3) hold_req = 1'b1;
      // prime the first eight taps with fresh coefficients
      for (int i = 0; i < 8; i++)
        send_beat(OP_COEF_WR, pick_sample(), TAP_IDX_W'(i), pick_sample());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender pause until the block has caught up
        if (p == 5 && n == PHASE_ITEMS / 2) wait_results();
        send_random_beat();
      end
    end

    settle();
    if (chk_errors == 0 && drain_failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
